### src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay: shared definitions
// Widths, sample and gain types, register indexes and reset values used by
// the channel interfaces and the delay core.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Delay store geometry. The depth must be a power of two so that the
    // read and write addresses wrap by plain modular arithmetic.
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

    // Sample and gain formats. Gains are unsigned Q1.14.
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 15;
    localparam int GAIN_FRAC   = 14;
    localparam int DELAY_BITS  = 16;

    // Product of a sample and a gain carries one extra sign bit for the gain.
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic        [ADDR_BITS-1:0]      addr_t;
    typedef logic signed [SAMPLE_BITS-1:0]    sample_t;
    typedef logic        [GAIN_BITS-1:0]      gain_t;
    typedef logic        [DELAY_BITS-1:0]     delay_t;
    typedef logic signed [PROD_BITS-1:0]      prod_t;
    typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic        [CFG_DATA_BITS-1:0]  cfg_data_t;

    // Register indexes.
    localparam cfg_index_t REG_DELAY_SAMPLES = 2'd0;
    localparam cfg_index_t REG_FEEDBACK_GAIN = 2'd1;
    localparam cfg_index_t REG_WET_GAIN      = 2'd2;

    // Register values after reset.
    localparam delay_t DELAY_RESET    = 16'd9600;
    localparam gain_t  FEEDBACK_RESET = 15'd8192;
    localparam gain_t  WET_RESET      = 15'd8192;

    // Saturation limits of one sample.
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endpackage

### src/sfd_in_if.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay: input frame channel
// Valid/ready channel carrying one dry stereo frame per word.
// ----------------------------------------------------------------------------
interface sfd_in_if;
    import sfd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_in;
    sample_t right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);

endinterface

### src/sfd_out_if.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay: output frame channel
// Valid/ready channel carrying one mixed stereo frame per word.
// ----------------------------------------------------------------------------
interface sfd_out_if;
    import sfd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);

endinterface

### src/sfd_cfg_if.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay: configuration write channel
// Valid/ready channel carrying a register index and the data to write.
// ----------------------------------------------------------------------------
interface sfd_cfg_if;
    import sfd_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

### src/stereo_feedback_delay.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay
// Echo with one circular delay store per channel and a shared write pointer.
// Each frame reads the delayed sample, stores dry plus delayed times the
// feedback gain, and outputs dry plus delayed times the wet gain, both
// rounded from Q1.14 and saturated to the sample width.
//
//   Channel  Role     Word
//   -------  -------  ---------------------------------------------
//   dry      sink     left_in, right_in: one stereo frame
//   mix      source   left_out, right_out: one mixed stereo frame
//   cfg      sink     index, data: one register write, always ready
//
// An accepted word passes the multiply stage, the write-back stage and
// the output register. One frame is accepted per cycle unless mix stalls
// or a frame holds; with a delay of one frame, each frame waits in the
// multiply stage for the previous frame's value to be written and forwarded.
// After reset the stores read as zero without a clearing pass: entries
// behind the write pointer, or all entries once it has wrapped, are live.
// A stalled mix holds the output register; the stages behind it keep
// filling until each is occupied.
// ----------------------------------------------------------------------------
module stereo_feedback_delay (
    input  logic      clk,
    input  logic      rst_n,
    sfd_in_if.sink    dry,
    sfd_out_if.source mix,
    sfd_cfg_if.sink   cfg
);
    import sfd_pkg::*;

    localparam int ACC_BITS = PROD_BITS + 2;
    localparam int RES_BITS = ACC_BITS - GAIN_FRAC;
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (GAIN_FRAC - 1);

    // Dry sample plus rounded gain term, saturated to the sample range.
    function automatic sample_t mix_sat(sample_t x, prod_t p);
        logic signed [ACC_BITS-1:0] acc;
        logic signed [RES_BITS-1:0] res;
        acc = (ACC_BITS'(x) <<< GAIN_FRAC) + ACC_BITS'(p) + ROUND_HALF;
        res = acc[ACC_BITS-1:GAIN_FRAC];
        if (res > RES_BITS'(SAMPLE_MAX))
            return SAMPLE_MAX;
        else if (res < RES_BITS'(SAMPLE_MIN))
            return SAMPLE_MIN;
        else
            return sample_t'(res[SAMPLE_BITS-1:0]);
    endfunction

    // Configuration registers
    delay_t delay_samples_reg;
    gain_t  feedback_gain_reg;
    gain_t  wet_gain_reg;

    // Write pointer and fill marker
    addr_t wr_ptr_reg;
    addr_t wr_ptr_next;
    logic  wrapped_reg;
    logic  wrapped_next;

    // Read address stage
    addr_t rd_addr;
    logic  rd_blank;
    logic  in_fire;

    // Delay stores and their registered read data
    sample_t left_mem  [STORE_DEPTH];
    sample_t right_mem [STORE_DEPTH];
    sample_t q_left_reg;
    sample_t q_right_reg;

    // Multiply stage
    logic    p1_valid_reg;
    logic    p1_valid_next;
    addr_t   p1_rd_reg;
    addr_t   p1_wr_reg;
    sample_t p1_left_reg;
    sample_t p1_right_reg;
    logic    p1_blank_reg;
    logic    p1_fwd_reg;
    sample_t p1_fwd_left_reg;
    sample_t p1_fwd_right_reg;
    sample_t d_left;
    sample_t d_right;
    logic signed [GAIN_BITS:0] fb_gain;
    logic signed [GAIN_BITS:0] wet_gain;
    prod_t   fb_left;
    prod_t   fb_right;
    prod_t   wet_left;
    prod_t   wet_right;
    logic    p1_block;
    logic    p1_fire;
    logic    p1_free;

    // Accumulate and write-back stage
    logic    p2_valid_reg;
    logic    p2_valid_next;
    addr_t   p2_wr_reg;
    sample_t p2_left_reg;
    sample_t p2_right_reg;
    prod_t   p2_fb_left_reg;
    prod_t   p2_fb_right_reg;
    prod_t   p2_wet_left_reg;
    prod_t   p2_wet_right_reg;
    sample_t st_left;
    sample_t st_right;
    sample_t mx_left;
    sample_t mx_right;
    logic    p2_fire;
    logic    p2_free;
    addr_t   fwd_addr;
    logic    fwd_hit;

    // Output register
    logic    mix_valid_reg;
    logic    mix_valid_next;
    sample_t mix_left_reg;
    sample_t mix_right_reg;

    // Flow control: each stage moves when the one ahead of it is free.
    // A frame whose read entry is still waiting to be written by the frame
    // in the write-back stage holds in the multiply stage.
    always_comb
    begin
        p2_fire  = p2_valid_reg && (!mix_valid_reg || mix.ready);
        p2_free  = !p2_valid_reg || p2_fire;
        p1_block = p2_valid_reg && (p2_wr_reg == p1_rd_reg);
        p1_fire  = p1_valid_reg && p2_free && !p1_block;
        p1_free  = !p1_valid_reg || p1_fire;
        in_fire  = dry.valid && p1_free;
    end

    assign dry.ready     = p1_free;
    assign cfg.ready     = 1'b1;
    assign mix.valid     = mix_valid_reg;
    assign mix.left_out  = mix_left_reg;
    assign mix.right_out = mix_right_reg;

    // Read address and whether that entry has ever been written.
    always_comb
    begin
        rd_addr      = wr_ptr_reg - addr_t'(delay_samples_reg);
        rd_blank     = !wrapped_reg && (rd_addr >= wr_ptr_reg);
        wr_ptr_next  = in_fire ? wr_ptr_reg + addr_t'(1) : wr_ptr_reg;
        wrapped_next = wrapped_reg || (in_fire && (wr_ptr_reg == '1));
    end

    // Stage valid bits.
    always_comb
    begin
        p1_valid_next  = in_fire || (p1_valid_reg && !p1_fire);
        p2_valid_next  = p1_fire || (p2_valid_reg && !p2_fire);
        mix_valid_next = p2_fire || (mix_valid_reg && !mix.ready);
    end

    // Delayed sample selection and gain products.
    always_comb
    begin
        if (p1_fwd_reg)
        begin
            d_left  = p1_fwd_left_reg;
            d_right = p1_fwd_right_reg;
        end
        else if (p1_blank_reg)
        begin
            d_left  = '0;
            d_right = '0;
        end
        else
        begin
            d_left  = q_left_reg;
            d_right = q_right_reg;
        end
        fb_gain   = {1'b0, feedback_gain_reg};
        wet_gain  = {1'b0, wet_gain_reg};
        fb_left   = d_left * fb_gain;
        fb_right  = d_right * fb_gain;
        wet_left  = d_left * wet_gain;
        wet_right = d_right * wet_gain;
    end

    // Store values, output values and the forwarding match.
    always_comb
    begin
        st_left  = mix_sat(p2_left_reg, p2_fb_left_reg);
        st_right = mix_sat(p2_right_reg, p2_fb_right_reg);
        mx_left  = mix_sat(p2_left_reg, p2_wet_left_reg);
        mx_right = mix_sat(p2_right_reg, p2_wet_right_reg);
        fwd_addr = in_fire ? rd_addr : p1_rd_reg;
        fwd_hit  = p2_fire && (p2_wr_reg == fwd_addr);
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg <= DELAY_RESET;
            feedback_gain_reg <= FEEDBACK_RESET;
            wet_gain_reg      <= WET_RESET;
            wr_ptr_reg        <= '0;
            wrapped_reg       <= 1'b0;
            p1_valid_reg      <= 1'b0;
            p1_fwd_reg        <= 1'b0;
            p2_valid_reg      <= 1'b0;
            mix_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_DELAY_SAMPLES: delay_samples_reg <= cfg.data[DELAY_BITS-1:0];
                    REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg.data[GAIN_BITS-1:0];
                    REG_WET_GAIN:      wet_gain_reg      <= cfg.data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            wr_ptr_reg    <= wr_ptr_next;
            wrapped_reg   <= wrapped_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            mix_valid_reg <= mix_valid_next;
            if (in_fire)
                p1_fwd_reg <= fwd_hit;
            else if (fwd_hit)
                p1_fwd_reg <= 1'b1;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_rd_reg    <= rd_addr;
            p1_wr_reg    <= wr_ptr_reg;
            p1_left_reg  <= dry.left_in;
            p1_right_reg <= dry.right_in;
            p1_blank_reg <= rd_blank;
        end
        if (fwd_hit)
        begin
            p1_fwd_left_reg  <= st_left;
            p1_fwd_right_reg <= st_right;
        end
        if (p1_fire)
        begin
            p2_wr_reg        <= p1_wr_reg;
            p2_left_reg      <= p1_left_reg;
            p2_right_reg     <= p1_right_reg;
            p2_fb_left_reg   <= fb_left;
            p2_fb_right_reg  <= fb_right;
            p2_wet_left_reg  <= wet_left;
            p2_wet_right_reg <= wet_right;
        end
        if (p2_fire)
        begin
            mix_left_reg  <= mx_left;
            mix_right_reg <= mx_right;
        end
    end

    // Delay stores: write-back from the last stage, read on acceptance.
    always_ff @(posedge clk)
    begin
        if (p2_fire)
        begin
            left_mem[p2_wr_reg]  <= st_left;
            right_mem[p2_wr_reg] <= st_right;
        end
        if (in_fire)
        begin
            q_left_reg  <= left_mem[rd_addr];
            q_right_reg <= right_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // Frames in the two compute stages are consecutive in write order.
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && p2_valid_reg |-> p1_wr_reg == p2_wr_reg + addr_t'(1))
        else $error("compute stages out of write order");

    // A forwarded entry is always one that has been written.
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && p1_fwd_reg |-> !p1_blank_reg)
        else $error("forwarded entry marked as never written");

    // A frame waiting on a pending write stays in the multiply stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && p1_block |=> p1_valid_reg && $stable(p1_wr_reg))
        else $error("frame left the multiply stage before its entry was written");
`endif

endmodule
